// ===== rtl/lbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbpc_pkg
// Shared types and constants of the LED blink pattern controller.
// ----------------------------------------------------------------------------
package lbpc_pkg;

  localparam int unsigned LED_COUNT_DEF = 4;   // default number of LEDs
  localparam int unsigned OUT_LEDS      = 4;   // LEDs visible on the result
  localparam int unsigned TIME_W        = 32;  // timestamp width
  localparam int unsigned REG_W         = 16;  // configuration register width
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned ARM_PHASES    = 6;   // on/off phases of the arm flash
  localparam int unsigned DIV_STEPS     = 32;  // one quotient bit per cycle
  localparam int unsigned DIV_CNT_W     = 5;

  // register reset values
  localparam logic [REG_W-1:0] SLOW_RST  = 16'd500;
  localparam logic [REG_W-1:0] FAST_RST  = 16'd125;
  localparam logic [REG_W-1:0] PON_RST   = 16'd100;
  localparam logic [REG_W-1:0] PPER_RST  = 16'd1000;
  localparam logic [REG_W-1:0] STSTP_RST = 16'd200;
  localparam logic [REG_W-1:0] ARSTP_RST = 16'd100;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SET_MODE  = 3'd1,
    OP_FORCE     = 3'd2,
    OP_TOGGLE    = 3'd3,
    OP_ALL_OFF   = 3'd4,
    OP_ALL_ON    = 3'd5,
    OP_SELF_TEST = 3'd6,
    OP_ARM       = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'd0,
    MODE_ON    = 3'd1,
    MODE_SLOW  = 3'd2,
    MODE_FAST  = 3'd3,
    MODE_PULSE = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOW_HALF  = 3'd0,
    CFG_FAST_HALF  = 3'd1,
    CFG_PULSE_ON   = 3'd2,
    CFG_PULSE_PER  = 3'd3,
    CFG_SELF_STEP  = 3'd4,
    CFG_ARM_STEP   = 3'd5
  } cfg_e;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [1:0]        led_index;
    logic [2:0]        mode;
    logic              turn_on;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [OUT_LEDS-1:0] lit_mask;
    logic [OUT_LEDS-1:0] pin_levels;
    logic                self_test_done;
    logic                arm_effect_busy;
  } res_t;

endpackage

// ===== rtl/lbpc_stream_if.sv =====
// ----------------------------------------------------------------------------
// lbpc_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface lbpc_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/led_blink_pattern_controller_top.sv =====
// ----------------------------------------------------------------------------
// led_blink_pattern_controller_top
// Per-LED mode engine with self-test sweep and arm flash effects.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                   accepted when
//  --------  ---  ----------------------------------------  -------------------
//  cmd_i     in   opcode, led_index, mode, turn_on, now_ms  valid & ready
//  res_o     out  lit_mask, pin_levels, self_test_done,     valid & ready
//                 arm_effect_busy
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i           cfg_we_i high
//
//  Commands other than tick are applied when taken; their result is registered
//  and shows on res_o the cycle after the item is taken.
//  A tick runs bit-serial restoring division (one quotient bit per cycle in
//  every lane at once), then an apply step that waits for a free result
//  register, then the result register. A new item is taken only while no
//  tick is in progress, as long as the result register is free or drains in
//  the same cycle. Reset clears all but the payload registers.
//
module led_blink_pattern_controller_top
  import lbpc_pkg::*;
#(
  parameter int unsigned LED_COUNT = LED_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  lbpc_stream_if.sink          cmd_i,
  lbpc_stream_if.source        res_o
);

  // width of the truncated self-test step number (below 2*LED_COUNT)
  localparam int unsigned ST_W = (LED_COUNT > 1) ? $clog2(2 * LED_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DIV   = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  // configuration registers
  logic [REG_W-1:0] slow_q, fast_q, pon_q, pper_q, ststp_q, arstp_q;

  // LED state
  logic [2:0]          mode_q [LED_COUNT];
  logic [2:0]          mode_d [LED_COUNT];
  logic [LED_COUNT-1:0] lit_q, lit_d;
  logic [TIME_W-1:0]   last_q [LED_COUNT];
  logic [TIME_W-1:0]   last_d [LED_COUNT];
  logic                st_run_q, st_run_d, arm_run_q, arm_run_d;
  logic [TIME_W-1:0]   st_begin_q, st_begin_d, arm_begin_q, arm_begin_d;

  // tick sequencing
  state_e              state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [TIME_W-1:0]   now_q;

  // division lanes: one per LED for the pulse phase, one for the effect step
  logic [TIME_W-1:0]   dvd_q [LED_COUNT];
  logic [REG_W-1:0]    rem_q [LED_COUNT];
  logic [TIME_W-1:0]   edvd_q;
  logic [REG_W-1:0]    erem_q;

  // result register
  logic                out_vld_q;
  res_t                out_q, out_d;

  logic in_fire, out_free, apply_go;

  // per-lane evaluation at apply time
  logic [TIME_W-1:0]    elapsed [LED_COUNT];
  logic [LED_COUNT-1:0] slow_hit, fast_hit, pulse_lit;
  logic                 st_end, arm_end;
  logic [ST_W-1:0]      stl;

  // one restoring division step: shift in the next dividend bit, subtract
  // if it fits, shift the quotient bit into the freed dividend slot
  function automatic logic [TIME_W+REG_W-1:0] div_step(
    input logic [REG_W-1:0]  rem,
    input logic [TIME_W-1:0] dvd,
    input logic [REG_W-1:0]  dvs
  );
    logic [REG_W:0]   trial;
    logic             ge;
    logic [REG_W-1:0] rem_n;
    trial = {rem, dvd[TIME_W-1]};
    ge    = trial >= {1'b0, dvs};
    rem_n = ge ? REG_W'(trial - {1'b0, dvs}) : trial[REG_W-1:0];
    return {rem_n, dvd[TIME_W-2:0], ge};
  endfunction

  assign out_free     = !out_vld_q || res_o.ready;
  assign cmd_i.ready  = (state_q == S_IDLE) && out_free;
  assign in_fire      = cmd_i.valid && cmd_i.ready;
  assign apply_go     = (state_q == S_APPLY) && out_free;
  assign res_o.valid  = out_vld_q;
  assign res_o.data   = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q  <= SLOW_RST;
      fast_q  <= FAST_RST;
      pon_q   <= PON_RST;
      pper_q  <= PPER_RST;
      ststp_q <= STSTP_RST;
      arstp_q <= ARSTP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLOW_HALF: slow_q  <= cfg_data_i;
        CFG_FAST_HALF: fast_q  <= cfg_data_i;
        CFG_PULSE_ON:  pon_q   <= cfg_data_i;
        CFG_PULSE_PER: pper_q  <= cfg_data_i;
        CFG_SELF_STEP: ststp_q <= cfg_data_i;
        CFG_ARM_STEP:  arstp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tick evaluation terms, valid once the lanes have finished
  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      elapsed[i]   = now_q - last_q[i];
      slow_hit[i]  = elapsed[i] >= {16'd0, slow_q};
      fast_hit[i]  = elapsed[i] >= {16'd0, fast_q};
      // zero period: the phase is the elapsed time itself
      pulse_lit[i] = (pper_q == '0) ? (elapsed[i] < {16'd0, pon_q})
                                    : (rem_q[i] < pon_q);
    end
  end

  assign st_end  = edvd_q >= TIME_W'(2 * LED_COUNT);
  assign arm_end = edvd_q >= TIME_W'(ARM_PHASES);
  assign stl     = edvd_q[ST_W-1:0];

  // next LED state: command at accept, or tick at apply
  always_comb begin
    mode_d      = mode_q;
    lit_d       = lit_q;
    last_d      = last_q;
    st_run_d    = st_run_q;
    st_begin_d  = st_begin_q;
    arm_run_d   = arm_run_q;
    arm_begin_d = arm_begin_q;

    if (in_fire) begin
      unique case (cmd_i.data.opcode)
        OP_TICK: ;
        OP_SET_MODE: begin
          for (int i = 0; i < LED_COUNT; i++) begin
            if ({30'd0, cmd_i.data.led_index} == 32'(i)) begin
              mode_d[i] = cmd_i.data.mode;
              last_d[i] = '0;
            end
          end
        end
        OP_FORCE: begin
          for (int i = 0; i < LED_COUNT; i++) begin
            if ({30'd0, cmd_i.data.led_index} == 32'(i)) begin
              mode_d[i] = cmd_i.data.turn_on ? MODE_ON : MODE_OFF;
              lit_d[i]  = cmd_i.data.turn_on;
            end
          end
        end
        OP_TOGGLE: begin
          for (int i = 0; i < LED_COUNT; i++) begin
            if ({30'd0, cmd_i.data.led_index} == 32'(i)) begin
              lit_d[i] = !lit_q[i];
            end
          end
        end
        OP_ALL_OFF: begin
          for (int i = 0; i < LED_COUNT; i++) mode_d[i] = MODE_OFF;
          lit_d = '0;
        end
        OP_ALL_ON: begin
          for (int i = 0; i < LED_COUNT; i++) mode_d[i] = MODE_ON;
          lit_d = '1;
        end
        OP_SELF_TEST: begin
          st_run_d   = 1'b1;
          st_begin_d = cmd_i.data.now_ms;
          for (int i = 0; i < LED_COUNT; i++) mode_d[i] = MODE_OFF;
          lit_d = '0;
        end
        OP_ARM: begin
          arm_run_d   = 1'b1;
          arm_begin_d = cmd_i.data.now_ms;
        end
        default: ;
      endcase
    end

    if (apply_go) begin
      if (st_run_q) begin
        if (st_end) begin
          st_run_d = 1'b0;
          for (int i = 0; i < LED_COUNT; i++) mode_d[i] = MODE_OFF;
          lit_d = '0;
        end else if (stl < ST_W'(LED_COUNT)) begin
          // walking single LED
          for (int i = 0; i < LED_COUNT; i++) begin
            mode_d[i] = MODE_OFF;
            lit_d[i]  = (ST_W'(i) == stl);
          end
        end else begin
          // second half: LEDs 0 up to stl - LED_COUNT dark, the rest lit
          for (int i = 0; i < LED_COUNT; i++) begin
            mode_d[i] = MODE_ON;
            lit_d[i]  = ((ST_W+1)'(i) + (ST_W+1)'(LED_COUNT)) > {1'b0, stl};
          end
        end
      end else if (arm_run_q) begin
        if (arm_end) begin
          arm_run_d = 1'b0;
        end else begin
          lit_d = {LED_COUNT{!edvd_q[0]}};
        end
      end else begin
        for (int i = 0; i < LED_COUNT; i++) begin
          case (mode_q[i])
            MODE_OFF: lit_d[i] = 1'b0;
            MODE_ON:  lit_d[i] = 1'b1;
            MODE_SLOW: begin
              if (slow_hit[i]) begin
                lit_d[i]  = !lit_q[i];
                last_d[i] = now_q;
              end
            end
            MODE_FAST: begin
              if (fast_hit[i]) begin
                lit_d[i]  = !lit_q[i];
                last_d[i] = now_q;
              end
            end
            MODE_PULSE: lit_d[i] = pulse_lit[i];
            default: ;  // unknown modes keep their lit state
          endcase
        end
      end
    end
  end

  // result built from the next lit state
  always_comb begin
    out_d.lit_mask = '0;
    for (int b = 0; b < OUT_LEDS; b++) begin
      if (b < LED_COUNT) out_d.lit_mask[b] = lit_d[b];
    end
    out_d.pin_levels      = ~out_d.lit_mask;
    out_d.self_test_done  = !st_run_d;
    out_d.arm_effect_busy = arm_run_d;
  end

  // tick sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (cmd_i.data.opcode == OP_TICK)) begin
          state_d = S_DIV;
          cnt_d   = '0;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lit_q       <= '0;
      st_run_q    <= 1'b0;
      st_begin_q  <= '0;
      arm_run_q   <= 1'b0;
      arm_begin_q <= '0;
      out_vld_q   <= 1'b0;
      for (int i = 0; i < LED_COUNT; i++) begin
        mode_q[i] <= MODE_OFF;
        last_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lit_q       <= lit_d;
      st_run_q    <= st_run_d;
      st_begin_q  <= st_begin_d;
      arm_run_q   <= arm_run_d;
      arm_begin_q <= arm_begin_d;
      mode_q      <= mode_d;
      last_q      <= last_d;
      if ((in_fire && (cmd_i.data.opcode != OP_TICK)) || apply_go) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers: result, timestamp and division lanes
  always_ff @(posedge clk_i) begin
    if ((in_fire && (cmd_i.data.opcode != OP_TICK)) || apply_go) out_q <= out_d;
    if (in_fire && (cmd_i.data.opcode == OP_TICK)) begin
      now_q  <= cmd_i.data.now_ms;
      edvd_q <= cmd_i.data.now_ms - (st_run_q ? st_begin_q : arm_begin_q);
      erem_q <= '0;
      for (int i = 0; i < LED_COUNT; i++) begin
        dvd_q[i] <= cmd_i.data.now_ms - last_q[i];
        rem_q[i] <= '0;
      end
    end else if (state_q == S_DIV) begin
      // zero divisor yields an all-ones quotient, i.e. saturated
      {erem_q, edvd_q} <= div_step(erem_q, edvd_q, st_run_q ? ststp_q : arstp_q);
      for (int i = 0; i < LED_COUNT; i++) begin
        {rem_q[i], dvd_q[i]} <= div_step(rem_q[i], dvd_q[i], pper_q);
      end
    end
  end

endmodule
